// File: rtl/core/slew_limited_pwm_actuator_drive_assert.svh
// Assertion helpers shared by the RTL of the actuator drive.
// All checks are sampled on the rising clock edge and are off while reset is high.
`ifndef SLEW_LIMITED_PWM_ACTUATOR_DRIVE_ASSERT_SVH
`define SLEW_LIMITED_PWM_ACTUATOR_DRIVE_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define SLPAD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// An implication checked in the same cycle.
`define SLPAD_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/slpad_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package slpad_pkg;

   // Field widths.
   localparam int LEVEL_W   = 17;
   localparam int REQ_W     = 19;
   localparam int DT_W      = 16;
   localparam int RATE_W    = 24;
   localparam int PW_W      = 16;
   localparam int FREQ_W    = 16;
   localparam int RES_W     = 5;
   localparam int DUTY_W    = 16;

   // Stream and register port widths.
   localparam int IN_TDATA_W  = 40;
   localparam int OUT_TDATA_W = 56;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   // Shared unit widths.
   localparam int MUL_A_W = 24;
   localparam int MUL_B_W = 23;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int DIV_W   = 20;
   localparam int CNT_W   = 5;

   localparam logic [CNT_W-1:0] PER_DIV_STEPS  = CNT_W'(20);
   localparam logic [CNT_W-1:0] DUTY_DIV_STEPS = CNT_W'(16);

   localparam logic [LEVEL_W-1:0] FULL_SCALE = LEVEL_W'(65536);
   localparam logic [DIV_W-1:0]   US_PER_S   = DIV_W'(1000000);
   localparam logic [RES_W-1:0]   MAX_RES    = RES_W'(16);

   // Slew step division by 1000. A rate product of 1000 * 65536 or more caps the
   // step at full scale. Below that, the product shifted right by three is under
   // 2^23, and multiplying by ceil(2^30 / 125) then shifting by 30 gives the exact
   // quotient by 125 over that whole range.
   localparam logic [PROD_W-1:0]  STEP_CAP_PROD    = PROD_W'(65536000);
   localparam logic [MUL_A_W-1:0] STEP_RECIP       = MUL_A_W'(8589935);
   localparam int                 STEP_RECIP_SHIFT = 30;

   // Register reset values.
   localparam logic [RATE_W-1:0] RATE_RESET   = RATE_W'(131072);
   localparam logic [PW_W-1:0]   CLOSED_RESET = PW_W'(1000);
   localparam logic [PW_W-1:0]   OPEN_RESET   = PW_W'(2000);
   localparam logic [FREQ_W-1:0] FREQ_RESET   = FREQ_W'(50);
   localparam logic [RES_W-1:0]  RES_RESET    = RES_W'(16);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MAX_SLEW_RATE      = 3'd0,
      CSR_CLOSED_PULSE_WIDTH = 3'd1,
      CSR_OPEN_PULSE_WIDTH   = 3'd2,
      CSR_PWM_FREQUENCY      = 3'd3,
      CSR_DUTY_RES_BITS      = 3'd4
   } csr_index_type;

   // Lower bound first: with open below closed, widths under closed give closed, others open.
   function automatic logic [PW_W-1:0] clamp_width(input logic [PW_W-1:0] w,
                                                   input logic [PW_W-1:0] lo,
                                                   input logic [PW_W-1:0] hi);
      logic [PW_W-1:0] r;
      if (w < lo) begin
         r = lo;
      end else if (w > hi) begin
         r = hi;
      end else begin
         r = w;
      end
      return r;
   endfunction

   function automatic logic [DUTY_W-1:0] max_duty(input logic [RES_W-1:0] bits);
      logic [RES_W-1:0]  b;
      logic [DUTY_W:0]   m;
      b = (bits > MAX_RES) ? MAX_RES : bits;
      m = ((DUTY_W+1)'(1) << b) - (DUTY_W+1)'(1);
      return m[DUTY_W-1:0];
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/slew_limited_pwm_actuator_drive.sv
// Channel | Dir | Fields (low bit first)
// req_    | in  | requested_level[18:0], elapsed_ms[34:19], enable[35], zero pad
// rsp_    | out | duty_value[15:0], pulse_width[31:16], commanded_level[48:32], zero pad
// csr_    | in  | write enable, register index, write data
//
// An enabled update computes the slew step, moves the level, forms the width and
// divides for the period and the duty; a disabled update closes the level and
// goes straight to the period division. A full-scale step skips the reciprocal
// multiply and a saturated duty skips the duty division. The shift-subtract divider
// makes 20 quotient bits for the period and 16 for the duty, one quotient bit per
// cycle, plus one shared multiplier step per product. The block takes one update at
// a time; req_tready is high only between updates. A finished result waits in the
// output register, and the next update is accepted while it waits. Synchronous reset
// clears the commanded level and loads the registers with their reset values.
`timescale 1ns / 1ps
`default_nettype none
`include "slew_limited_pwm_actuator_drive_assert.svh"

module slew_limited_pwm_actuator_drive
   import slpad_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // requested_level, elapsed_ms, enable
   input  logic [IN_TDATA_W-1:0]  req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // duty_value, pulse_width, commanded_level
   output logic [OUT_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   typedef enum logic [12:0] {
      ST_IDLE       = 13'b0000000000001,
      ST_STEP_MUL   = 13'b0000000000010,
      ST_STEP_CHK   = 13'b0000000000100,
      ST_STEP_RECIP = 13'b0000000001000,
      ST_UPDATE     = 13'b0000000010000,
      ST_MUL_CLOSED = 13'b0000000100000,
      ST_MUL_OPEN   = 13'b0000001000000,
      ST_WIDTH      = 13'b0000010000000,
      ST_PER_DIV    = 13'b0000100000000,
      ST_DUTY_MUL   = 13'b0001000000000,
      ST_DUTY_CHK   = 13'b0010000000000,
      ST_DUTY_DIV   = 13'b0100000000000,
      ST_DONE       = 13'b1000000000000
   } state_type;

   state_type           state_ff, state_in;
   logic [RATE_W-1:0]   rate_ff, rate_in;
   logic [PW_W-1:0]     closed_ff, closed_in;
   logic [PW_W-1:0]     open_ff, open_in;
   logic [FREQ_W-1:0]   freq_ff, freq_in;
   logic [RES_W-1:0]    res_ff, res_in;
   logic [LEVEL_W-1:0]  level_ff, level_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [LEVEL_W-1:0]  req_ff, req_in;
   logic [DT_W-1:0]     dt_ff, dt_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [32:0]         acc_ff, acc_in;
   logic [LEVEL_W-1:0]  step_ff, step_in;
   logic [PW_W-1:0]     width_ff, width_in;
   logic [DIV_W-1:0]    period_ff, period_in;
   logic [DIV_W-1:0]    rem_ff, rem_in;
   logic [DIV_W-1:0]    num_ff, num_in;
   logic [DIV_W-1:0]    div_ff, div_in;
   logic [DIV_W-1:0]    quo_ff, quo_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [DUTY_W-1:0]   duty_ff, duty_in;
   logic [DUTY_W-1:0]   rsp_duty_ff, rsp_duty_in;
   logic [PW_W-1:0]     rsp_width_ff, rsp_width_in;
   logic [LEVEL_W-1:0]  rsp_level_ff, rsp_level_in;

   logic [REQ_W-1:0]    req_raw;
   logic [DT_W-1:0]     req_dt;
   logic                req_en;
   logic [LEVEL_W-1:0]  req_clamped;
   logic                req_xfer;

   logic [MUL_A_W-1:0]  mul_a;
   logic [MUL_B_W-1:0]  mul_b;
   logic [PROD_W-1:0]   mul_p;

   logic [DIV_W+1:0]    div_diff;
   logic                div_ge;
   logic [DIV_W-1:0]    div_rem_next;
   logic [DIV_W-1:0]    div_quo_next;
   logic                div_last;
   logic                div_busy;

   logic [DUTY_W-1:0]   maxd;
   logic [LEVEL_W:0]    lvl_up;
   logic [LEVEL_W-1:0]  lvl_down;
   logic [33:0]         width_sum;
   logic [DIV_W-1:0]    freq_div;

   assign req_raw  = req_tdata[REQ_W-1:0];
   assign req_dt   = req_tdata[REQ_W+DT_W-1:REQ_W];
   assign req_en   = req_tdata[REQ_W+DT_W];
   assign req_xfer = req_tvalid && req_tready;

   // Negative requests close; requests above full scale are held at full scale.
   assign req_clamped = req_raw[REQ_W-1] ? '0 :
                        (req_raw[REQ_W-2:0] > {1'b0, FULL_SCALE}) ? FULL_SCALE :
                        req_raw[LEVEL_W-1:0];

   assign maxd     = max_duty(res_ff);
   assign freq_div = (freq_ff == '0) ? DIV_W'(1) : {{(DIV_W-FREQ_W){1'b0}}, freq_ff};

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(OUT_TDATA_W-DUTY_W-PW_W-LEVEL_W){1'b0}},
                        rsp_level_ff, rsp_width_ff, rsp_duty_ff};

   // Shared multiplier, operands chosen by the sequencer.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_STEP_MUL: begin
            mul_a = rate_ff;
            mul_b = {{(MUL_B_W-DT_W){1'b0}}, dt_ff};
         end
         ST_STEP_RECIP: begin
            mul_a = STEP_RECIP;
            mul_b = prod_ff[MUL_B_W+2:3];
         end
         ST_MUL_CLOSED: begin
            mul_a = {{(MUL_A_W-PW_W){1'b0}}, closed_ff};
            mul_b = {{(MUL_B_W-LEVEL_W){1'b0}}, FULL_SCALE - level_ff};
         end
         ST_MUL_OPEN: begin
            mul_a = {{(MUL_A_W-PW_W){1'b0}}, open_ff};
            mul_b = {{(MUL_B_W-LEVEL_W){1'b0}}, level_ff};
         end
         ST_DUTY_MUL: begin
            mul_a = {{(MUL_A_W-PW_W){1'b0}}, width_ff};
            mul_b = {{(MUL_B_W-DUTY_W){1'b0}}, maxd};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};

   // Shared restoring divider: one quotient bit per cycle, dividend bits enter
   // from the top of num_ff.
   assign div_diff     = {1'b0, rem_ff, num_ff[DIV_W-1]} - {2'b00, div_ff};
   assign div_ge       = !div_diff[DIV_W+1];
   assign div_rem_next = div_ge ? div_diff[DIV_W-1:0] : {rem_ff[DIV_W-2:0], num_ff[DIV_W-1]};
   assign div_quo_next = {quo_ff[DIV_W-2:0], div_ge};
   assign div_last     = (cnt_ff == CNT_W'(1));
   assign div_busy     = (state_ff == ST_PER_DIV) || (state_ff == ST_DUTY_DIV);

   assign lvl_up    = {1'b0, level_ff} + {1'b0, step_ff};
   assign lvl_down  = (level_ff > step_ff) ? (level_ff - step_ff) : '0;
   assign width_sum = {1'b0, acc_ff} + {1'b0, prod_ff[32:0]};

   always_comb begin
      state_in     = state_ff;
      rate_in      = rate_ff;
      closed_in    = closed_ff;
      open_in      = open_ff;
      freq_in      = freq_ff;
      res_in       = res_ff;
      level_in     = level_ff;
      rsp_valid_in = rsp_valid_ff;
      req_in       = req_ff;
      dt_in        = dt_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      step_in      = step_ff;
      width_in     = width_ff;
      period_in    = period_ff;
      rem_in       = rem_ff;
      num_in       = num_ff;
      div_in       = div_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      duty_in      = duty_ff;
      rsp_duty_in  = rsp_duty_ff;
      rsp_width_in = rsp_width_ff;
      rsp_level_in = rsp_level_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_SLEW_RATE:      rate_in   = csr_wdata[RATE_W-1:0];
            CSR_CLOSED_PULSE_WIDTH: closed_in = csr_wdata[PW_W-1:0];
            CSR_OPEN_PULSE_WIDTH:   open_in   = csr_wdata[PW_W-1:0];
            CSR_PWM_FREQUENCY:      freq_in   = csr_wdata[FREQ_W-1:0];
            CSR_DUTY_RES_BITS:      res_in    = csr_wdata[RES_W-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               req_in = req_clamped;
               dt_in  = req_dt;
               if (req_en) begin
                  state_in = ST_STEP_MUL;
               end else begin
                  level_in = '0;
                  width_in = clamp_width(closed_ff, closed_ff, open_ff);
                  rem_in   = '0;
                  num_in   = US_PER_S;
                  div_in   = freq_div;
                  quo_in   = '0;
                  cnt_in   = PER_DIV_STEPS;
                  state_in = ST_PER_DIV;
               end
            end
         end
         ST_STEP_MUL: begin
            prod_in  = mul_p;
            state_in = ST_STEP_CHK;
         end
         ST_STEP_CHK: begin
            // A quotient of 65536 or more is capped at full scale without dividing.
            if (prod_ff >= STEP_CAP_PROD) begin
               step_in  = FULL_SCALE;
               state_in = ST_UPDATE;
            end else begin
               state_in = ST_STEP_RECIP;
            end
         end
         ST_STEP_RECIP: begin
            // Division by 1000: a shift by three, then a reciprocal multiply for 125.
            step_in  = mul_p[STEP_RECIP_SHIFT +: LEVEL_W];
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (req_ff > level_ff) begin
               level_in = (lvl_up < {1'b0, req_ff}) ? lvl_up[LEVEL_W-1:0] : req_ff;
            end else begin
               level_in = (lvl_down > req_ff) ? lvl_down : req_ff;
            end
            state_in = ST_MUL_CLOSED;
         end
         ST_MUL_CLOSED: begin
            prod_in  = mul_p;
            state_in = ST_MUL_OPEN;
         end
         ST_MUL_OPEN: begin
            acc_in   = prod_ff[32:0];
            prod_in  = mul_p;
            state_in = ST_WIDTH;
         end
         ST_WIDTH: begin
            width_in = clamp_width(width_sum[31:16], closed_ff, open_ff);
            rem_in   = '0;
            num_in   = US_PER_S;
            div_in   = freq_div;
            quo_in   = '0;
            cnt_in   = PER_DIV_STEPS;
            state_in = ST_PER_DIV;
         end
         ST_PER_DIV: begin
            rem_in = div_rem_next;
            num_in = {num_ff[DIV_W-2:0], 1'b0};
            quo_in = div_quo_next;
            cnt_in = cnt_ff - CNT_W'(1);
            if (div_last) begin
               period_in = div_quo_next;
               state_in  = ST_DUTY_MUL;
            end
         end
         ST_DUTY_MUL: begin
            prod_in  = mul_p;
            state_in = ST_DUTY_CHK;
         end
         ST_DUTY_CHK: begin
            // If the upper half already reaches the period, the quotient overflows
            // sixteen bits and the duty saturates.
            if ({{(DIV_W-16){1'b0}}, prod_ff[31:16]} >= period_ff) begin
               duty_in  = maxd;
               state_in = ST_DONE;
            end else begin
               rem_in   = {{(DIV_W-16){1'b0}}, prod_ff[31:16]};
               num_in   = {prod_ff[15:0], {(DIV_W-16){1'b0}}};
               div_in   = period_ff;
               quo_in   = '0;
               cnt_in   = DUTY_DIV_STEPS;
               state_in = ST_DUTY_DIV;
            end
         end
         ST_DUTY_DIV: begin
            rem_in = div_rem_next;
            num_in = {num_ff[DIV_W-2:0], 1'b0};
            quo_in = div_quo_next;
            cnt_in = cnt_ff - CNT_W'(1);
            if (div_last) begin
               duty_in  = (div_quo_next[DUTY_W-1:0] > maxd) ? maxd :
                          div_quo_next[DUTY_W-1:0];
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_duty_in  = duty_ff;
               rsp_width_in = width_ff;
               rsp_level_in = level_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rate_ff      <= RATE_RESET;
         closed_ff    <= CLOSED_RESET;
         open_ff      <= OPEN_RESET;
         freq_ff      <= FREQ_RESET;
         res_ff       <= RES_RESET;
         level_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rate_ff      <= rate_in;
         closed_ff    <= closed_in;
         open_ff      <= open_in;
         freq_ff      <= freq_in;
         res_ff       <= res_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      dt_ff        <= dt_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      step_ff      <= step_in;
      width_ff     <= width_in;
      period_ff    <= period_in;
      rem_ff       <= rem_in;
      num_ff       <= num_in;
      div_ff       <= div_in;
      quo_ff       <= quo_in;
      duty_ff      <= duty_in;
      rsp_duty_ff  <= rsp_duty_in;
      rsp_width_ff <= rsp_width_in;
      rsp_level_ff <= rsp_level_in;
   end

   // The commanded level never leaves the Q16 unit range.
   `SLPAD_ASSERT(a_level_range, level_ff <= FULL_SCALE, "commanded level above full scale")

   // A divide pass always has quotient bits left to produce.
   `SLPAD_ASSERT_IMPLY(a_div_count, div_busy, cnt_ff != '0, "divider running with zero count")

   // The slew step is capped before the level update uses it.
   `SLPAD_ASSERT_IMPLY(a_step_cap, state_ff == ST_UPDATE, step_ff <= FULL_SCALE, "slew step above full scale")

   // A delivered duty word never exceeds the maximum for the resolution.
   `SLPAD_ASSERT_IMPLY(a_duty_sat, rsp_valid_ff, rsp_duty_ff <= maxd, "duty above maximum")

endmodule

`default_nettype wire

// File: bench/slew_limited_pwm_actuator_drive_tb.sv
`timescale 1ns / 1ps

module slew_limited_pwm_actuator_drive_tb;
   import slpad_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int SETTLE_TICKS = 100;
   localparam int REPORT_MAX   = 10;

   typedef struct packed {
      logic        enable;
      logic [15:0] elapsed_ms;
      logic [18:0] requested;
   } update_item_t;

   typedef struct packed {
      logic [16:0] level;
      logic [15:0] width;
      logic [15:0] duty;
   } drive_result_t;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [IN_TDATA_W-1:0]  req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [OUT_TDATA_W-1:0] rsp_tdata;
   logic                   csr_we     = 1'b0;
   csr_index_type          csr_index  = CSR_MAX_SLEW_RATE;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   // Shadow copy of the register file and the commanded opening.
   logic [23:0] slew_rate_cfg   = RATE_RESET;
   logic [15:0] closed_pw_cfg   = CLOSED_RESET;
   logic [15:0] open_pw_cfg     = OPEN_RESET;
   logic [15:0] pwm_freq_cfg    = FREQ_RESET;
   logic [4:0]  duty_bits_cfg   = RES_RESET;
   logic [16:0] commanded_model = '0;

   update_item_t  pending_updates[$];
   drive_result_t expected_drive[$];
   update_item_t  item_on_bus;
   int            req_gap      = 0;
   int            rsp_gap      = 0;
   int            stall_pct    = 0;
   int            mismatches   = 0;
   int            cycle_count  = 0;

   slew_limited_pwm_actuator_drive dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Advances the commanded opening by one update and returns the drive outputs.
   function automatic drive_result_t compute_update(input update_item_t it);
      drive_result_t r;
      logic [16:0]   target;
      logic [63:0]   step;
      logic [63:0]   moved;
      logic [63:0]   num;
      logic [63:0]   duty;
      logic [31:0]   width;
      logic [31:0]   freq;
      logic [31:0]   period;
      logic [31:0]   top_duty;
      logic [4:0]    bits;
      if (!it.enable) begin
         commanded_model = '0;
         width = 32'(closed_pw_cfg);
      end else begin
         if (it.requested[18]) begin
            target = '0;
         end else if (it.requested > 19'd65536) begin
            target = 17'd65536;
         end else begin
            target = it.requested[16:0];
         end
         step = (64'(slew_rate_cfg) * 64'(it.elapsed_ms)) / 64'd1000;
         if (step > 64'd65536) begin
            step = 64'd65536;
         end
         if (target > commanded_model) begin
            moved = 64'(commanded_model) + step;
            commanded_model = (moved < 64'(target)) ? moved[16:0] : target;
         end else begin
            moved = (64'(commanded_model) > step) ? 64'(commanded_model) - step : 64'd0;
            commanded_model = (moved > 64'(target)) ? moved[16:0] : target;
         end
         num = 64'(closed_pw_cfg) * (64'd65536 - 64'(commanded_model))
             + 64'(open_pw_cfg) * 64'(commanded_model);
         width = num[47:16];
      end
      // With open below closed, the closed bound wins only for widths under it; others clamp to open.
      if (width < 32'(closed_pw_cfg)) begin
         width = 32'(closed_pw_cfg);
      end else if (width > 32'(open_pw_cfg)) begin
         width = 32'(open_pw_cfg);
      end
      freq = (pwm_freq_cfg == '0) ? 32'd1 : 32'(pwm_freq_cfg);
      bits = (duty_bits_cfg > 5'd16) ? 5'd16 : duty_bits_cfg;
      top_duty = (32'd1 << bits) - 32'd1;
      period = 32'd1000000 / freq;
      duty = (64'(width) * 64'(top_duty)) / 64'(period);
      if (duty > 64'(top_duty)) begin
         duty = 64'(top_duty);
      end
      r.duty  = duty[15:0];
      r.width = width[15:0];
      r.level = commanded_model;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      mismatches++;
      if (mismatches <= REPORT_MAX) begin
         $display("%0t: %s differs: expected %0d, got %0d", $realtime, what, want, got);
      end
   endtask

   // Input side: one transfer per accepted update, with random idle bursts.
   always @(posedge clock) begin
      update_item_t nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap    <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_drive.push_back(compute_update(item_on_bus));
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap != 0) begin
               req_tvalid <= 1'b0;
               req_gap    <= req_gap - 1;
            end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
               req_tvalid <= 1'b0;
               req_gap    <= $urandom_range(0, 3);
            end else if (pending_updates.size() != 0) begin
               nxt = pending_updates.pop_front();
               item_on_bus <= nxt;
               req_tdata   <= IN_TDATA_W'(nxt);
               req_tvalid  <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result side: compares each transfer with the oldest expected drive word.
   always @(posedge clock) begin
      drive_result_t got;
      drive_result_t want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_gap    <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(drive_result_t)-1:0];
            if (expected_drive.size() == 0) begin
               report_mismatch("unexpected result, duty", 32'd0, 32'(got.duty));
            end else begin
               want = expected_drive.pop_front();
               if (got.duty != want.duty) begin
                  report_mismatch("duty_value", 32'(want.duty), 32'(got.duty));
               end
               if (got.width != want.width) begin
                  report_mismatch("pulse_width", 32'(want.width), 32'(got.width));
               end
               if (got.level != want.level) begin
                  report_mismatch("commanded_level", 32'(want.level), 32'(got.level));
               end
            end
         end
         if (rsp_gap != 0) begin
            rsp_tready <= 1'b0;
            rsp_gap    <= rsp_gap - 1;
         end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            rsp_tready <= 1'b0;
            rsp_gap    <= $urandom_range(0, 3);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic write_register(input csr_index_type idx, input logic [23:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      case (idx)
         CSR_MAX_SLEW_RATE:      slew_rate_cfg = value;
         CSR_CLOSED_PULSE_WIDTH: closed_pw_cfg = value[15:0];
         CSR_OPEN_PULSE_WIDTH:   open_pw_cfg   = value[15:0];
         CSR_PWM_FREQUENCY:      pwm_freq_cfg  = value[15:0];
         CSR_DUTY_RES_BITS:      duty_bits_cfg = value[4:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic write_settings(input logic [23:0] rate, input logic [15:0] closed_pw,
                                 input logic [15:0] open_pw, input logic [15:0] freq,
                                 input logic [4:0] bits);
      write_register(CSR_MAX_SLEW_RATE, rate);
      write_register(CSR_CLOSED_PULSE_WIDTH, 24'(closed_pw));
      write_register(CSR_OPEN_PULSE_WIDTH, 24'(open_pw));
      write_register(CSR_PWM_FREQUENCY, 24'(freq));
      write_register(CSR_DUTY_RES_BITS, 24'(bits));
   endtask

   task automatic queue_update(input logic [18:0] requested, input logic [15:0] dt,
                               input logic en);
      update_item_t it;
      it.requested  = requested;
      it.elapsed_ms = dt;
      it.enable     = en;
      pending_updates.push_back(it);
   endtask

   // Mostly runs of updates that chase one target, so the limiter ramps all the
   // way; some items carry a stray request in the middle of a run.
   task automatic queue_random_updates(input int count);
      logic [18:0] target;
      logic [18:0] requested;
      logic [15:0] dt;
      logic        en;
      int          held;
      held = 0;
      target = '0;
      for (int i = 0; i < count; i++) begin
         if (held == 0) begin
            case ($urandom_range(0, 7))
               0: target = 19'(32'd0 - $urandom_range(1, 131072));
               1: target = 19'($urandom_range(65536, 131072));
               2: target = 19'($urandom);
               3: target = '0;
               4: target = 19'd65536;
               default: target = 19'($urandom_range(0, 65536));
            endcase
            held = $urandom_range(1, 16);
         end
         held--;
         requested = ($urandom_range(0, 9) == 0) ? 19'($urandom) : target;
         case ($urandom_range(0, 9))
            0: dt = '0;
            1: dt = 16'($urandom);
            2: dt = 16'($urandom_range(200, 2000));
            default: dt = 16'($urandom_range(1, 40));
         endcase
         en = ($urandom_range(0, 11) != 0);
         queue_update(requested, dt, en);
      end
   endtask

   task automatic wait_until_idle();
      while (pending_updates.size() != 0 || req_tvalid || expected_drive.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   initial begin
      logic [15:0] lo_pw;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: extremes of each field, full-scale steps, disable.
      stall_pct = 0;
      queue_update(19'd0, 16'd0, 1'b1);
      queue_update(19'd65536, 16'd1, 1'b1);
      queue_update(19'd65536, 16'd65535, 1'b1);
      queue_update(19'd131072, 16'd10, 1'b1);
      queue_update(19'(-131072), 16'd10, 1'b1);
      queue_update(19'(-1), 16'd65535, 1'b1);
      queue_update(19'd65535, 16'd200, 1'b1);
      queue_update(19'd65537, 16'd300, 1'b1);
      queue_update(19'd32768, 16'd0, 1'b1);
      queue_update(19'd131071, 16'd1000, 1'b1);
      queue_update(19'd65536, 16'd500, 1'b0);
      queue_update(19'd65536, 16'd20, 1'b1);
      queue_update(19'd12345, 16'd65535, 1'b1);
      queue_update(19'd0, 16'd1, 1'b1);
      queue_update(19'h7FFFF, 16'hFFFF, 1'b0);
      queue_update(19'd40000, 16'd7, 1'b1);
      wait_until_idle();

      stall_pct = 30;
      write_settings(RATE_RESET, CLOSED_RESET, OPEN_RESET, FREQ_RESET, RES_RESET);
      queue_random_updates(80);
      wait_until_idle();

      stall_pct = 0;
      write_settings(24'hFFFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 5'd16);
      queue_random_updates(80);
      wait_until_idle();

      // No slew at all, a single-width window and a one-bit resolution.
      stall_pct = 40;
      write_settings(24'd0, 16'd1500, 16'd1500, 16'd1, 5'd1);
      queue_random_updates(60);
      wait_until_idle();

      // Open width below closed, zero frequency and zero resolution.
      stall_pct = 25;
      write_settings(24'd65536, 16'd2000, 16'd1000, 16'd0, 5'd0);
      queue_random_updates(80);
      wait_until_idle();

      stall_pct = 20;
      write_settings(24'd65536, 16'd500, 16'd2500, 16'd400, 5'd31);
      queue_random_updates(80);
      wait_until_idle();

      for (int p = 0; p < 5; p++) begin
         stall_pct = (p % 2 == 0) ? 35 : 10;
         lo_pw = 16'($urandom_range(0, 3000));
         write_settings(($urandom_range(0, 3) == 0) ? 24'($urandom)
                                                    : 24'($urandom_range(0, 300000)),
                        lo_pw,
                        ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                    : lo_pw + 16'($urandom_range(0, 3000)),
                        ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(20, 500)),
                        5'($urandom_range(0, 31)));
         queue_random_updates(80);
         wait_until_idle();
      end

      // Closing stretch at full rate on both sides.
      stall_pct = 0;
      write_settings(24'd131072, 16'd1000, 16'd2000, 16'd333, 5'd12);
      queue_random_updates(100);
      wait_until_idle();

      repeat (SETTLE_TICKS) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/slpad_pkg.sv
rtl/core/slew_limited_pwm_actuator_drive.sv
bench/slew_limited_pwm_actuator_drive_tb.sv
